// ===== rtl/core/brfdc_pkg.sv =====
// ============================================================================
// brfdc_pkg
// Shared types, codes and reset values of the buzzer resampler with FIFO and
// DC blocker.
// ============================================================================
`default_nettype none

package brfdc_pkg;

    // Default ring FIFO depth in samples
    localparam int FIFO_DEPTH_DEF = 4096;

    // Field widths
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = 16;
    localparam int TOTAL_W    = 32;
    localparam int RATE_W     = 16;
    localparam int LEVEL_W    = 15;
    localparam int POLE_W     = 15;
    localparam int SIL_CFG_W  = 13;
    localparam int PHASE_W    = 17;
    localparam int POLE_SHIFT = 15;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Transaction kinds
    localparam t_kind KIND_TICK  = 3'd0;
    localparam t_kind KIND_SET   = 3'd1;
    localparam t_kind KIND_PULL  = 3'd2;
    localparam t_kind KIND_START = 3'd3;
    localparam t_kind KIND_STOP  = 3'd4;

    // Configuration register indexes
    localparam t_cfg_idx CFG_OUTPUT_RATE = 3'd0;
    localparam t_cfg_idx CFG_OSC_RATE    = 3'd1;
    localparam t_cfg_idx CFG_LEVEL       = 3'd2;
    localparam t_cfg_idx CFG_POLE        = 3'd3;
    localparam t_cfg_idx CFG_SILENCE     = 3'd4;

    // Configuration reset values
    localparam logic [RATE_W-1:0]    RST_OUTPUT_RATE = 16'd44100;
    localparam logic [RATE_W-1:0]    RST_OSC_RATE    = 16'd32768;
    localparam logic [LEVEL_W-1:0]   RST_LEVEL       = 15'd7000;
    localparam logic [POLE_W-1:0]    RST_POLE        = 15'd32604;
    localparam logic [SIL_CFG_W-1:0] RST_SILENCE     = 13'd1024;

    // Lowest phase wrap threshold
    localparam logic [RATE_W-1:0] MIN_OSC_RATE = 16'd32768;

endpackage

`default_nettype wire

// ===== rtl/core/brfdc_ram.sv =====
// ============================================================================
// brfdc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
`default_nettype none

module brfdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/buzzer_resample_fifo_dc_block_unit.sv =====
// ============================================================================
// buzzer_resample_fifo_dc_block_unit
// Resamples a one-bit buzzer into a 16-bit audio stream through a ring FIFO
// held in RAM, and filters each pulled sample with a DC blocker.
// ============================================================================
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | i_valid / o_ready       | i_kind, i_buzzer_on, i_buffer_end
//  result   | o_valid / i_ready       | o_sample, o_underrun_total
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A tick pushes no sample, one, or two when the phase wraps twice; with
//  one RAM write port the second is registered and written after the first.
//  A pull passes through the registered RAM read and the filter feedback
//  loop (pole multiply registered, then add and clamp). Reset is synchronous,
//  active low; the FIFO RAM is not cleared. Every kind waits during a second
//  push or a filter cycle; a pull also waits while the result register holds
//  an untaken transaction. Config writes are always taken.
// ============================================================================
`default_nettype none

module buzzer_resample_fifo_dc_block_unit #(
    parameter int FIFO_DEPTH = brfdc_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input transactions
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [brfdc_pkg::KIND_W-1:0]       i_kind,
    input  wire logic                               i_buzzer_on,
    input  wire logic                               i_buffer_end,
    // result transactions
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [brfdc_pkg::SAMPLE_W-1:0]   o_sample,
    output logic        [brfdc_pkg::TOTAL_W-1:0]    o_underrun_total,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [brfdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [brfdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import brfdc_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * FIFO_DEPTH - 1);
    localparam logic [PW-1:0] DEPTH_P  = PW'(FIFO_DEPTH);
    localparam logic [PW:0]   TWO_DEPTH = (PW + 1)'(2 * FIFO_DEPTH);
    localparam int PROD_W = 48;
    localparam int ACC_W  = PHASE_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RATE_W-1:0]    r_output_rate;
    logic [RATE_W-1:0]    r_osc_rate;
    logic [LEVEL_W-1:0]   r_level;
    logic [POLE_W-1:0]    r_pole;
    logic [SIL_CFG_W-1:0] r_silence_cfg;

    assign o_cfg_ready = 1'b1;

    // Decode and hold configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_rate <= RST_OUTPUT_RATE;
            r_osc_rate    <= RST_OSC_RATE;
            r_level       <= RST_LEVEL;
            r_pole        <= RST_POLE;
            r_silence_cfg <= RST_SILENCE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OUTPUT_RATE: r_output_rate <= i_cfg_data[RATE_W-1:0];
                CFG_OSC_RATE:    r_osc_rate    <= i_cfg_data[RATE_W-1:0];
                CFG_LEVEL:       r_level       <= i_cfg_data[LEVEL_W-1:0];
                CFG_POLE:        r_pole        <= i_cfg_data[POLE_W-1:0];
                CFG_SILENCE:     r_silence_cfg <= i_cfg_data[SIL_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Block state
    // ------------------------------------------------------------------
    logic [PW-1:0]          r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]          r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]          r_silence, n_silence;
    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic                   r_buzzer_bit, n_buzzer_bit;
    logic                   r_running, n_running;
    logic signed [SAMPLE_W-1:0] r_prev_in, n_prev_in;
    logic signed [31:0]     r_prev_out, n_prev_out;
    logic                   r_underflowed, n_underflowed;
    logic [TOTAL_W-1:0]     r_underrun, n_underrun;
    logic                   r_push2, n_push2;
    logic [SAMPLE_W-1:0]    r_push_val, n_push_val;
    logic                   r_pb_valid, n_pb_valid;
    logic                   r_pb_run, n_pb_run;
    logic                   r_pb_ram, n_pb_ram;
    logic signed [PROD_W-1:0] r_prod;
    logic                   r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [TOTAL_W-1:0]     r_out_total;

    // RAM interface
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_W-1:0]    ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_W-1:0]    ram_rdata;

    brfdc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // FIFO occupancy
    // ------------------------------------------------------------------
    logic [PW:0]   cnt_ext;
    logic [PW-1:0] stored;
    logic [PW:0]   fill;
    logic          fifo_full;
    logic [PW-1:0] wr_slot;
    logic [PW-1:0] rd_slot;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_next;

    assign cnt_ext = (r_wr_ptr >= r_rd_ptr) ? {1'b0, r_wr_ptr} - {1'b0, r_rd_ptr}
                                            : {1'b0, r_wr_ptr} + TWO_DEPTH - {1'b0, r_rd_ptr};
    assign stored    = cnt_ext[PW-1:0];
    assign fill      = {1'b0, r_silence} + {1'b0, stored};
    assign fifo_full = fill >= {1'b0, DEPTH_P};
    assign wr_slot   = (r_wr_ptr >= DEPTH_P) ? r_wr_ptr - DEPTH_P : r_wr_ptr;
    assign rd_slot   = (r_rd_ptr >= DEPTH_P) ? r_rd_ptr - DEPTH_P : r_rd_ptr;
    assign wr_next   = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next   = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    // ------------------------------------------------------------------
    // Phase accumulator, at most two wraps per tick
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]    thr;
    logic [ACC_W-1:0]    acc0;
    logic [ACC_W-1:0]    acc1;
    logic [ACC_W-1:0]    acc2;
    logic                wrap1;
    logic                wrap2;
    logic [SAMPLE_W-1:0] level_ext;
    logic [SAMPLE_W-1:0] tick_val;

    assign thr   = {2'b00, (r_osc_rate < MIN_OSC_RATE) ? MIN_OSC_RATE : r_osc_rate};
    assign acc0  = {1'b0, r_phase} + {2'b00, r_output_rate};
    assign wrap1 = acc0 >= thr;
    assign acc1  = wrap1 ? acc0 - thr : acc0;
    assign wrap2 = wrap1 && (acc1 >= thr);
    assign acc2  = wrap2 ? acc1 - thr : acc1;

    assign level_ext = {1'b0, r_level};
    assign tick_val  = r_buzzer_bit ? level_ext : -level_ext;

    // Start silence, saturated to the FIFO depth
    logic [PW-1:0] sil_load;
    assign sil_load = (32'(r_silence_cfg) > 32'(FIFO_DEPTH)) ? DEPTH_P
                                                             : PW'(r_silence_cfg);

    // ------------------------------------------------------------------
    // DC blocker, filter step of a pull
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]   prod_adj;
    logic signed [PROD_W-1:0]   prod_q;
    logic signed [31:0]         fb;
    logic signed [SAMPLE_W-1:0] x_in;
    logic signed [31:0]         y_full;
    logic                       sat_hi;
    logic                       sat_lo;
    logic signed [SAMPLE_W-1:0] y_sat;

    // Truncate the feedback toward zero: bias negative products before shift
    assign prod_adj = r_prod + (r_prod[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
    assign prod_q   = prod_adj >>> POLE_SHIFT;
    assign fb       = prod_q[31:0];
    assign x_in     = r_pb_ram ? ram_rdata : '0;
    assign y_full   = 32'(x_in) - 32'(r_prev_in) + fb;
    assign sat_hi   = !y_full[31] && (|y_full[30:15]);
    assign sat_lo   = y_full[31] && !(&y_full[30:15]);
    assign y_sat    = sat_hi ? 16'sh7FFF : (sat_lo ? 16'sh8000 : y_full[15:0]);

    // ------------------------------------------------------------------
    // Input handshake: hold off during a second push or a filter cycle;
    // a pull also waits for a free result register
    // ------------------------------------------------------------------
    logic accept;
    assign o_ready = !r_push2 && !r_pb_valid &&
                     ((i_kind != KIND_PULL) || !r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    logic                push_req;
    logic [SAMPLE_W-1:0] push_data;
    logic                pull_uf;
    logic                uf_new;

    always_comb begin
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_silence     = r_silence;
        n_phase       = r_phase;
        n_buzzer_bit  = r_buzzer_bit;
        n_running     = r_running;
        n_prev_in     = r_prev_in;
        n_prev_out    = r_prev_out;
        n_underflowed = r_underflowed;
        n_underrun    = r_underrun;
        n_push2       = 1'b0;
        n_push_val    = r_push_val;
        n_pb_valid    = 1'b0;
        n_pb_run      = r_pb_run;
        n_pb_ram      = r_pb_ram;
        push_req      = 1'b0;
        push_data     = r_push_val;
        pull_uf       = 1'b0;
        uf_new        = r_underflowed;
        ram_re        = 1'b0;
        ram_we        = 1'b0;

        // Finish the second push of a double-wrap tick
        if (r_push2) begin
            push_req  = 1'b1;
            push_data = r_push_val;
        end

        // Close the filter loop
        if (r_pb_valid && r_pb_run) begin
            n_prev_in  = x_in;
            n_prev_out = y_full;
        end

        if (accept) begin
            unique case (i_kind)
                KIND_TICK: begin
                    n_phase    = acc2[PHASE_W-1:0];
                    push_req   = wrap1;
                    push_data  = tick_val;
                    n_push2    = wrap2;
                    n_push_val = tick_val;
                end
                KIND_SET: begin
                    n_buzzer_bit = i_buzzer_on;
                end
                KIND_PULL: begin
                    n_pb_valid = 1'b1;
                    n_pb_run   = r_running;
                    n_pb_ram   = 1'b0;
                    if (r_running) begin
                        if (r_silence != '0) begin
                            n_silence = r_silence - 1'b1;
                        end else if (stored != '0) begin
                            ram_re   = 1'b1;
                            n_rd_ptr = rd_next;
                            n_pb_ram = 1'b1;
                        end else begin
                            pull_uf = 1'b1;
                        end
                    end
                    uf_new = r_underflowed | pull_uf;
                    if (i_buffer_end) begin
                        n_underrun    = r_underrun + TOTAL_W'(uf_new);
                        n_underflowed = 1'b0;
                    end else begin
                        n_underflowed = uf_new;
                    end
                end
                KIND_START: begin
                    n_rd_ptr      = '0;
                    n_wr_ptr      = '0;
                    n_underrun    = '0;
                    n_underflowed = 1'b0;
                    n_buzzer_bit  = 1'b0;
                    n_phase       = '0;
                    n_prev_in     = '0;
                    n_prev_out    = '0;
                    n_silence     = sil_load;
                    n_running     = 1'b1;
                end
                KIND_STOP: begin
                    n_running = 1'b0;
                    n_rd_ptr  = '0;
                    n_wr_ptr  = '0;
                    n_silence = '0;
                end
                default: ;
            endcase
        end

        // Push into the FIFO, drop when full
        if (push_req && !fifo_full) begin
            ram_we   = 1'b1;
            n_wr_ptr = wr_next;
        end
    end

    assign ram_waddr = wr_slot[AW-1:0];
    assign ram_wdata = push_data;
    assign ram_raddr = rd_slot[AW-1:0];

    // Control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_silence     <= '0;
            r_phase       <= '0;
            r_buzzer_bit  <= 1'b0;
            r_running     <= 1'b0;
            r_prev_in     <= '0;
            r_prev_out    <= '0;
            r_underflowed <= 1'b0;
            r_underrun    <= '0;
            r_push2       <= 1'b0;
            r_pb_valid    <= 1'b0;
        end else begin
            r_rd_ptr      <= n_rd_ptr;
            r_wr_ptr      <= n_wr_ptr;
            r_silence     <= n_silence;
            r_phase       <= n_phase;
            r_buzzer_bit  <= n_buzzer_bit;
            r_running     <= n_running;
            r_prev_in     <= n_prev_in;
            r_prev_out    <= n_prev_out;
            r_underflowed <= n_underflowed;
            r_underrun    <= n_underrun;
            r_push2       <= n_push2;
            r_pb_valid    <= n_pb_valid;
        end
    end

    // Payload registers; register the pole product on pull acceptance
    always_ff @(posedge i_clk) begin
        r_push_val <= n_push_val;
        r_pb_run   <= n_pb_run;
        r_pb_ram   <= n_pb_ram;
        if (accept && (i_kind == KIND_PULL)) begin
            r_prod <= r_prev_out * $signed({1'b0, r_pole});
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pb_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pb_valid) begin
            r_out_sample <= r_pb_run ? y_sat : '0;
            r_out_total  <= r_underrun;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_sample         = r_out_sample;
    assign o_underrun_total = r_out_total;

endmodule

`default_nettype wire
